### hdl/bpa_pkg.sv
// bpa_pkg: shared constants, state codes and the step-unit result type
// of the buddy page allocator; depends on nothing
package bpa_pkg;

	localparam int NUM_PAGES_DEF  = 1024;
	localparam int MAX_ORDERS_DEF = 11;
	localparam int XW             = 17;
	localparam int ORD_W          = 5;
	localparam int IN_ORD_W       = 4;
	localparam int PAGE_W         = 10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic [XW-1:0] buddy;
		logic [XW-1:0] pair_idx;
		logic [XW-1:0] up_blk;
		logic [XW-1:0] align_blk;
		logic [XW-1:0] add_blk;
	} step_t;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_FIND  = 10'b0000000100,
		S_RM_RD = 10'b0000001000,
		S_RM_WR = 10'b0000010000,
		S_FCHK  = 10'b0000100000,
		S_TG_RD = 10'b0001000000,
		S_TG_WR = 10'b0010000000,
		S_AP_A  = 10'b0100000000,
		S_AP_B  = 10'b1000000000
	} state_t;

endpackage

### hdl/bpa_ram.sv
// bpa_ram: generic single-write, single-read ram with registered read
// no package dependency
module bpa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/bpa_step_unit.sv
// bpa_step_unit: shared shift, mask and add unit giving buddy, pair index,
// aligned and next block addresses for one block and order; uses bpa_pkg
module bpa_step_unit (
	input  logic [bpa_pkg::XW-1:0]    blk,
	input  logic [bpa_pkg::ORD_W-1:0] ord,
	output bpa_pkg::step_t            res
);
	import bpa_pkg::*;

	logic [XW-1:0] bit_lo;
	logic [XW-1:0] bit_up;

	assign bit_lo        = XW'(1) << ord;
	assign bit_up        = bit_lo << 1;
	assign res.buddy     = blk ^ bit_lo;
	assign res.pair_idx  = (blk >> ord) >> 1;
	assign res.up_blk    = blk & ~(bit_up - XW'(1));
	assign res.align_blk = blk & ~(bit_lo - XW'(1));
	assign res.add_blk   = blk + bit_lo;
endmodule

### hdl/buddy_page_allocator.sv
// buddy_page_allocator: binary buddy allocator top level with sequencer,
// list heads and tails; uses bpa_pkg, bpa_ram, bpa_step_unit
//
// usage: one input channel (in_valid/in_stall) carries operation,
// block_order and page_index; one output channel (out_valid/out_stall)
// carries failed and granted_page, exactly one result per input transfer.
// an allocate returns the first page of a block of 2^block_order pages or
// failed; a free returns failed = 0, granted_page = 0.
// the block works on one item at a time: in_stall is high from the
// transfer until its result has moved into the output register.
// allocate: scans up to MAX_ORDERS orders for a free block, then unlinks
// and toggles the head block and appends and toggles at each split level.
// free: each merge level checks, toggles and unlinks the buddy, then the
// last buddy check and the append; an invalid order or page finishes on
// the transfer. a result goes through the holding register to out_valid.
// every level is one pass through the shared link and pair-bit rams.
// after reset the pair-bit ram is cleared, one word a cycle, all NUM_PAGES
// words, with in_stall high; all free lists start empty.
// while out_stall holds a result in the output register the next result
// waits in a holding register, and in_stall stays high until it moves.
module buddy_page_allocator #(
	parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
	parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [bpa_pkg::IN_ORD_W-1:0] block_order,
	input  logic [bpa_pkg::PAGE_W-1:0]   page_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         failed,
	output logic [bpa_pkg::PAGE_W-1:0]   granted_page
);
	import bpa_pkg::*;

	localparam int PW  = $clog2(NUM_PAGES);
	localparam int LW  = PW + 1;
	localparam int OIW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam logic [LW-1:0] LINK_NONE = '1;

	function automatic logic link_ok(input logic [LW-1:0] v);
		return XW'(v) < XW'(NUM_PAGES);
	endfunction

	state_t              state_q;
	logic [ORD_W-1:0]    o_q, tgt_q;
	logic [XW-1:0]       blk_q;
	logic [PW-1:0]       node_q, t_q, clr_q;
	logic                alloc_q, phase_q;
	logic [LW-1:0]       head_q [MAX_ORDERS];
	logic [LW-1:0]       tail_q [MAX_ORDERS];
	logic                res_fail_q;
	logic [PAGE_W-1:0]   res_page_q;
	logic                out_valid_q, failed_q;
	logic [PAGE_W-1:0]   granted_q;
	logic                done;
	logic                pend_q;
	logic                in_take;

	logic [XW-1:0]       su_blk;
	logic [ORD_W-1:0]    su_ord;
	step_t               step;
	logic [OIW-1:0]      oi;
	logic [LW-1:0]       head_cur, tail_cur;

	logic                nx_we, pv_we, pr_we;
	logic [PW-1:0]       nx_wa, pv_wa, pr_wa, pr_ra;
	logic [LW-1:0]       nx_wd, pv_wd, nx_rd, pv_rd;
	logic [MAX_ORDERS-1:0] pr_wd, pr_rd;

	assign su_blk = (state_q == S_IDLE) ? XW'(page_index) : blk_q;
	assign su_ord = (state_q == S_IDLE) ? ORD_W'(block_order) : o_q;

	bpa_step_unit u_step (.blk(su_blk), .ord(su_ord), .res(step));

	assign oi       = o_q[OIW-1:0];
	assign head_cur = head_q[oi];
	assign tail_cur = tail_q[oi];
	assign pr_ra    = step.pair_idx[PW-1:0];

	bpa_ram #(.W(LW), .DEPTH(NUM_PAGES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(node_q), .rdata(nx_rd)
	);
	bpa_ram #(.W(LW), .DEPTH(NUM_PAGES)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(node_q), .rdata(pv_rd)
	);
	bpa_ram #(.W(MAX_ORDERS), .DEPTH(NUM_PAGES)) u_pair_ram (
		.clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd)
	);

	always_comb begin
		nx_we = 1'b0;
		nx_wa = blk_q[PW-1:0];
		nx_wd = LINK_NONE;
		pv_we = 1'b0;
		pv_wa = blk_q[PW-1:0];
		pv_wd = tail_cur;
		pr_we = 1'b0;
		pr_wa = pr_ra;
		pr_wd = pr_rd ^ (MAX_ORDERS'(1) << oi);
		unique case (state_q)
			S_CLEAR: begin
				pr_we = 1'b1;
				pr_wa = clr_q;
				pr_wd = '0;
			end
			S_RM_WR: begin
				nx_we = link_ok(pv_rd);
				nx_wa = pv_rd[PW-1:0];
				nx_wd = nx_rd;
				pv_we = link_ok(nx_rd);
				pv_wa = nx_rd[PW-1:0];
				pv_wd = pv_rd;
			end
			S_TG_WR: begin
				pr_we = 1'b1;
			end
			S_AP_A: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			S_AP_B: begin
				nx_we = 1'b1;
				nx_wa = t_q;
				nx_wd = LW'(blk_q[PW-1:0]);
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE) || pend_q;
	assign in_take  = in_valid && !in_stall;
	assign done     = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			for (int i = 0; i < MAX_ORDERS; i++) begin
				head_q[i] <= LINK_NONE;
				tail_q[i] <= LINK_NONE;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!alloc_q && phase_q && !res_fail_q) begin
					end
				end
				S_RM_WR: begin
					if (!link_ok(pv_rd)) begin
						head_q[oi] <= nx_rd;
					end
					if (!link_ok(nx_rd)) begin
						tail_q[oi] <= pv_rd;
					end
				end
				S_AP_A: begin
					if (!link_ok(tail_cur)) begin
						head_q[oi] <= LW'(blk_q[PW-1:0]);
					end
					tail_q[oi] <= LW'(blk_q[PW-1:0]);
				end
				default: begin
				end
			endcase
			if (state_q == S_IDLE && in_take) begin
				if (operation == OP_ALLOC) begin
					state_q <= (int'(block_order) >= MAX_ORDERS) ? S_IDLE : S_FIND;
				end else if (int'(block_order) >= MAX_ORDERS
						|| XW'(page_index) >= XW'(NUM_PAGES)) begin
					state_q <= S_IDLE;
				end else begin
					state_q <= S_FCHK;
				end
			end
			if (state_q == S_FIND) begin
				if (link_ok(head_cur)) begin
					state_q <= S_RM_RD;
				end else if (int'(o_q) == MAX_ORDERS - 1) begin
					state_q <= S_IDLE;
				end
			end
			if (state_q == S_RM_RD) state_q <= S_RM_WR;
			if (state_q == S_RM_WR) state_q <= alloc_q ? S_TG_RD : S_FCHK;
			if (state_q == S_FCHK) begin
				if (int'(o_q) + 1 < MAX_ORDERS && step.buddy < XW'(NUM_PAGES)) begin
					state_q <= S_TG_RD;
				end else begin
					state_q <= S_AP_A;
				end
			end
			if (state_q == S_TG_RD) state_q <= S_TG_WR;
			if (state_q == S_TG_WR) begin
				if (alloc_q) begin
					state_q <= (o_q > tgt_q) ? S_AP_A : S_IDLE;
				end else begin
					state_q <= pr_rd[oi] ? S_RM_RD : S_AP_A;
				end
			end
			if (state_q == S_AP_A) begin
				if (link_ok(tail_cur)) begin
					state_q <= S_AP_B;
				end else begin
					state_q <= alloc_q ? S_TG_RD : S_IDLE;
				end
			end
			if (state_q == S_AP_B) state_q <= alloc_q ? S_TG_RD : S_IDLE;
		end
	end

	// result hand-off: a step that returns to idle marks its result pending;
	// the result moves out once the output register is free
	logic finishing;
	always_comb begin
		finishing = 1'b0;
		priority case (1'b1)
			state_q == S_IDLE && in_take: finishing =
				(operation == OP_ALLOC) ? (int'(block_order) >= MAX_ORDERS)
				: (int'(block_order) >= MAX_ORDERS || XW'(page_index) >= XW'(NUM_PAGES));
			state_q == S_FIND: finishing = !link_ok(head_cur) && int'(o_q) == MAX_ORDERS - 1;
			state_q == S_TG_WR: finishing = alloc_q && !(o_q > tgt_q);
			state_q == S_AP_A: finishing = !alloc_q && !link_ok(tail_cur);
			state_q == S_AP_B: finishing = !alloc_q;
			default: finishing = 1'b0;
		endcase
	end

	logic              fin_fail;
	logic [PAGE_W-1:0] fin_page;
	always_comb begin
		fin_fail = 1'b0;
		fin_page = '0;
		if (state_q == S_IDLE) begin
			fin_fail = (operation == OP_ALLOC);
		end else if (state_q == S_FIND) begin
			fin_fail = 1'b1;
		end else if (state_q == S_TG_WR) begin
			fin_page = phase_q ? step.add_blk[PAGE_W-1:0] : blk_q[PAGE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_take) begin
			alloc_q <= (operation == OP_ALLOC);
			o_q     <= ORD_W'(block_order);
			tgt_q   <= ORD_W'(block_order);
			phase_q <= 1'b0;
			blk_q   <= step.align_blk;
		end
		unique case (state_q)
			S_FIND: begin
				if (link_ok(head_cur)) begin
					node_q <= head_cur[PW-1:0];
					blk_q  <= XW'(head_cur[PW-1:0]);
				end else if (int'(o_q) != MAX_ORDERS - 1) begin
					o_q <= o_q + ORD_W'(1);
				end
			end
			S_RM_WR: begin
				if (!alloc_q) begin
					o_q   <= o_q + ORD_W'(1);
					blk_q <= step.up_blk;
				end
			end
			S_TG_WR: begin
				if (alloc_q) begin
					if (phase_q) begin
						blk_q <= step.add_blk;
					end
					if (o_q > tgt_q) begin
						o_q <= o_q - ORD_W'(1);
					end
				end else begin
					node_q <= step.buddy[PW-1:0];
				end
			end
			S_AP_A: begin
				t_q     <= tail_cur[PW-1:0];
				phase_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (finishing) begin
			res_fail_q <= fin_fail;
			res_page_q <= fin_page;
		end
	end

	// pending result waits in a holding flag until the output register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pend_q && done) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
				if (finishing) pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && done) begin
			failed_q  <= res_fail_q;
			granted_q <= res_page_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign failed       = failed_q;
	assign granted_page = granted_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> granted_page == '0)
		else $error("failed result carries a page");

	a_rise_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pend_q))
		else $error("result shown without a pending completion");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input taken during pair-bit clear");

	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !done |=> pend_q && $stable(res_fail_q) && $stable(res_page_q))
		else $error("pending result lost or changed");
endmodule

### test/tb.sv
// tb: self-checking testbench of buddy_page_allocator; random allocate and
// free traffic with an in-order scoreboard; uses bpa_pkg and the allocator rtl
`timescale 1ns / 1ps

class buddy_scoreboard;
	localparam int NP = bpa_pkg::NUM_PAGES_DEF;
	localparam int NO = bpa_pkg::MAX_ORDERS_DEF;
	localparam int unsigned NONE = 32'hFFFF_FFFF;

	int unsigned nxt[NP];
	int unsigned prv[NP];
	int unsigned head[NO];
	int unsigned tail[NO];
	int unsigned cnt[NO];
	bit pair[NO][NP];
	bit exp_failed[$];
	bit [9:0] exp_page[$];
	int errors;

	function new();
		foreach (nxt[i]) begin
			nxt[i] = 0;
			prv[i] = 0;
		end
		foreach (head[i]) begin
			head[i] = NONE;
			tail[i] = NONE;
			cnt[i] = 0;
		end
		foreach (pair[i, j]) pair[i][j] = 0;
		errors = 0;
	endfunction

	function int unsigned clip(int unsigned v);
		return v < NP ? v : NONE;
	endfunction

	function void unlink(int unsigned o, int unsigned node);
		int unsigned p, n;
		p = clip(prv[node]);
		n = clip(nxt[node]);
		if (p != NONE) nxt[p] = n;
		else head[o] = n;
		if (n != NONE) prv[n] = p;
		else tail[o] = p;
		cnt[o]--;
	endfunction

	function void link_tail(int unsigned o, int unsigned node);
		int unsigned t;
		t = clip(tail[o]);
		prv[node] = t;
		nxt[node] = NONE;
		if (t != NONE) nxt[t] = node;
		else head[o] = node;
		tail[o] = node;
		cnt[o]++;
	endfunction

	function bit flip(int unsigned o, int unsigned idx);
		bit old;
		if (o >= NO || idx >= NP) return 0;
		old = pair[o][idx];
		pair[o][idx] = !old;
		return old;
	endfunction

	function bit take_block(int unsigned ord, output int unsigned pg);
		int unsigned o;
		bit b;
		pg = NONE;
		if (ord >= NO) return 0;
		for (o = ord; o < NO; o++) begin
			pg = clip(head[o]);
			if (pg != NONE) break;
		end
		if (pg == NONE) return 0;
		unlink(o, pg);
		b = flip(o, pg >> (o + 1));
		while (o > ord) begin
			o--;
			link_tail(o, pg);
			b = flip(o, pg >> (o + 1));
			pg += 1 << o;
		end
		return 1;
	endfunction

	function void give_block(int unsigned ord, int unsigned page);
		int unsigned o, blk, bud;
		o = ord;
		if (ord >= NO || page >= NP) return;
		blk = page & ~((1 << o) - 1);
		while (o + 1 < NO) begin
			bud = blk ^ (1 << o);
			if (bud >= NP) break;
			if (flip(o, blk >> (o + 1)) == 0) break;
			unlink(o, bud);
			o++;
			blk &= ~((1 << o) - 1);
		end
		link_tail(o, blk);
	endfunction

	// note one accepted input transfer and queue its expected result
	function void note_transfer(bit op, bit [3:0] ord, bit [9:0] page,
			output bit f, output bit [9:0] g);
		int unsigned pg;
		f = 0;
		g = 0;
		if (op == bpa_pkg::OP_ALLOC) begin
			if (take_block(ord, pg)) g = pg[9:0];
			else f = 1;
		end else begin
			give_block(ord, page);
		end
		exp_failed.push_back(f);
		exp_page.push_back(g);
	endfunction

	function void check_result(bit f, bit [9:0] g);
		bit ef;
		bit [9:0] eg;
		if (exp_failed.size() == 0) begin
			$error("result with nothing expected: failed=%0d granted_page=%0d", f, g);
			errors++;
			return;
		end
		ef = exp_failed.pop_front();
		eg = exp_page.pop_front();
		if (f !== ef) begin
			$error("failed: expected %0d actual %0d", ef, f);
			errors++;
		end
		if (g !== eg) begin
			$error("granted_page: expected %0d actual %0d", eg, g);
			errors++;
		end
	endfunction

	function int pending();
		return exp_failed.size();
	endfunction
endclass

module tb;
	import bpa_pkg::*;

	localparam int NP = NUM_PAGES_DEF;
	localparam int NO = MAX_ORDERS_DEF;
	localparam int RANDOM_ITEMS = 1940;
	localparam int QUIET_ITEMS = 250;
	localparam int WATCHDOG = 8000;

	typedef struct {
		int unsigned page;
		int unsigned ord;
	} block_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic operation = OP_ALLOC;
	logic [IN_ORD_W-1:0] block_order = '0;
	logic [PAGE_W-1:0] page_index = '0;
	logic out_valid;
	logic out_stall = 0;
	logic failed;
	logic [PAGE_W-1:0] granted_page;

	buddy_scoreboard sb = new();
	block_t owned[$];
	bit quiet = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	buddy_page_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .block_order(block_order), .page_index(page_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.failed(failed), .granted_page(granted_page)
	);

	// one transfer; entered and left at a falling edge
	task automatic send(bit op, bit [3:0] ord, bit [9:0] page);
		bit f;
		bit [9:0] g;
		in_valid = 1;
		operation = op;
		block_order = ord;
		page_index = page;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(op, ord, page, f, g);
		if (op == OP_ALLOC && !f) owned.push_back('{g, ord});
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic free_owned();
		int k;
		block_t b;
		if (owned.size() == 0) return;
		k = $urandom_range(0, owned.size() - 1);
		b = owned[k];
		owned.delete(k);
		send(OP_FREE, 4'(b.ord), 10'(b.page | ($urandom & ((1 << b.ord) - 1))));
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 13)) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(failed, granted_page);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("[buddy_page_allocator] ERROR");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall = 1;
				repeat (300) @(negedge clk);
				out_stall = 0;
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	initial begin
		int p, k, maxk, r;
		// software starts owning all memory as a random set of aligned blocks
		p = 0;
		while (p < NP) begin
			maxk = 0;
			while (maxk + 1 < NO && (p % (1 << (maxk + 1))) == 0 &&
					p + (1 << (maxk + 1)) <= NP)
				maxk++;
			k = $urandom_range(0, maxk);
			owned.push_back('{p, k});
			p += 1 << k;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(OP_ALLOC, 4'd0, 10'd0);
		send(OP_ALLOC, 4'd15, 10'h3FF);
		send(OP_FREE, 4'd11, 10'h3FF);
		send(OP_FREE, 4'd15, 10'h155);
		send(OP_ALLOC, 4'd10, 10'd0);
		repeat (8) free_owned();
		send(OP_ALLOC, 4'd0, 10'h2AA);
		send(OP_ALLOC, 4'd10, 10'd0);
		send(OP_ALLOC, 4'd11, 10'd0);
		send(OP_ALLOC, 4'd3, 10'd0);
		if (owned.size() > 0) free_owned();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100) hold_off = 1;
			if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
			r = $urandom_range(0, 99);
			if (r < 3)
				send(OP_ALLOC, 4'($urandom_range(11, 15)), 10'($urandom));
			else if (r < 6)
				send(OP_FREE, 4'($urandom_range(11, 15)), 10'($urandom));
			else if (r < 50 || owned.size() == 0)
				send(OP_ALLOC, 4'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, NO - 1) : $urandom_range(0, 3)), 10'($urandom));
			else
				free_owned();
			sender_gap();
		end

		while (sb.pending() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("[buddy_page_allocator] OK");
		else $display("[buddy_page_allocator] ERROR");
		$finish;
	end
endmodule
